@@ rtl/gtpmc_pkg.sv @@
// Shared types and constants for the two-walker grid collector.
`default_nettype none
package gtpmc_pkg;

  // Upper limit of the side-length parameter; control fields are sized for it.
  localparam int unsigned SIDE_LIMIT = 128;
  localparam int unsigned DEF_MAX_SIDE = 64;
  localparam int unsigned CTL_W = 8;
  localparam int unsigned GSIZE_W = 7;
  localparam logic [GSIZE_W-1:0] GSIZE_RESET = 7'd64;

  // Decoded cell codes held in the per-row grid stores: {blocked, item}.
  localparam logic [1:0] CELL_EMPTY = 2'b00;
  localparam logic [1:0] CELL_ITEM = 2'b01;
  localparam logic [1:0] CELL_BLOCKED = 2'b10;

  // Raw input code that means one item.
  localparam logic [1:0] CODE_ITEM = 2'b01;

  // Broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic             diag_rd;
    logic             rd_en;
    logic             wr_en;
    logic             layer;
    logic             first;
    logic             row_ok;
    logic [CTL_W-1:0] t;
    logic [CTL_W-1:0] row;
    logic [CTL_W-1:0] lo;
    logic [CTL_W-1:0] hi;
    logic [CTL_W-1:0] lo_p;
    logic [CTL_W-1:0] hi_p;
    logic [1:0]       a_code;
    logic             cp_we;
    logic [CTL_W-1:0] cp_row;
    logic [CTL_W-1:0] cp_col;
    logic [1:0]       cp_code;
  } ctl_t;

endpackage
`default_nettype wire

@@ rtl/gtpmc_cell.sv @@
// One column cell of the chain: a grid row store and two score layers for one r2.
`default_nettype none
module gtpmc_cell #(
  parameter int unsigned MAX_SIDE = gtpmc_pkg::DEF_MAX_SIDE,
  parameter int unsigned IDX = 0
) (
  input  wire logic                                  clk,
  input  wire gtpmc_pkg::ctl_t                       ctl,
  input  wire logic                                  nb_cur_v,
  input  wire logic [$clog2(4*MAX_SIDE)-1:0]         nb_cur_s,
  input  wire logic                                  nb_prv_v,
  input  wire logic [$clog2(4*MAX_SIDE)-1:0]         nb_prv_s,
  output logic                                       cur_v,
  output logic [$clog2(4*MAX_SIDE)-1:0]              cur_s,
  output logic                                       prv_v,
  output logic [$clog2(4*MAX_SIDE)-1:0]              prv_s,
  output logic                                       new_v,
  output logic [$clog2(4*MAX_SIDE)-1:0]              new_s,
  output logic [1:0]                                 b_code
);
  import gtpmc_pkg::*;

  localparam int unsigned RW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned SC_W = $clog2(4*MAX_SIDE);
  localparam logic [CTL_W-1:0] IDX8 = CTL_W'(IDX);

  logic [1:0]      grid_mem [2**RW];
  logic [SC_W:0]   sc_mem [2**(RW+1)];
  logic [1:0]      b_r;
  logic [SC_W:0]   rd_r;
  logic            prv_v_r;
  logic [SC_W-1:0] prv_s_r;
  logic [CTL_W-1:0] col;
  logic            col_ok_p;
  logic            in_range;
  logic            best_v;
  logic [SC_W-1:0] best_s;
  logic            blk;
  logic [SC_W-1:0] gain;

  assign col = ctl.t - IDX8;

  always_ff @(posedge clk) begin
    if (ctl.cp_we && ctl.cp_row == IDX8) begin
      grid_mem[ctl.cp_col[RW-1:0]] <= ctl.cp_code;
    end
    if (ctl.diag_rd) begin
      b_r <= grid_mem[col[RW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_r <= sc_mem[{ctl.layer, ctl.row[RW-1:0]}];
    end
    if (ctl.wr_en && in_range) begin
      sc_mem[{~ctl.layer, ctl.row[RW-1:0]}] <= {new_v, new_s};
    end
  end

  // The previous row's score is kept fully masked; it is dropped at each diagonal start.
  always_ff @(posedge clk) begin
    if (ctl.diag_rd) begin
      prv_v_r <= 1'b0;
    end else if (ctl.wr_en) begin
      prv_v_r <= cur_v;
      prv_s_r <= cur_s;
    end
  end

  assign col_ok_p = (IDX8 >= ctl.lo_p) && (IDX8 <= ctl.hi_p);
  assign in_range = (IDX8 >= ctl.lo) && (IDX8 <= ctl.hi);
  assign cur_v = rd_r[SC_W] && col_ok_p && ctl.row_ok;
  assign cur_s = rd_r[SC_W-1:0];
  assign prv_v = prv_v_r;
  assign prv_s = prv_s_r;
  assign b_code = b_r;

  always_comb begin
    best_v = 1'b0;
    best_s = '0;
    if (cur_v) begin
      best_v = 1'b1;
      best_s = cur_s;
    end
    if (prv_v_r && (!best_v || prv_s_r > best_s)) begin
      best_v = 1'b1;
      best_s = prv_s_r;
    end
    if (nb_cur_v && (!best_v || nb_cur_s > best_s)) begin
      best_v = 1'b1;
      best_s = nb_cur_s;
    end
    if (nb_prv_v && (!best_v || nb_prv_s > best_s)) begin
      best_v = 1'b1;
      best_s = nb_prv_s;
    end
    if (ctl.first) begin
      best_v = 1'b1;
      best_s = '0;
    end
  end

  assign blk = ctl.a_code[1] | b_r[1];
  assign gain = SC_W'(ctl.a_code[0]) + ((ctl.row == IDX8) ? '0 : SC_W'(b_r[0]));
  assign new_v = best_v && !blk;
  assign new_s = best_s + gain;

endmodule
`default_nettype wire

@@ rtl/gtpmc_ctrl.sv @@
// Sequencer: grid loading, row redistribution, diagonal sweep and result register.
`default_nettype none
module gtpmc_ctrl #(
  parameter int unsigned MAX_SIDE = gtpmc_pkg::DEF_MAX_SIDE
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      in_tvalid,
  output logic                                           in_tready,
  input  wire logic [1:0]                                in_code,
  input  wire logic                                      in_tlast,
  output logic                                           out_tvalid,
  input  wire logic                                      out_tready,
  output logic [7:0]                                     out_total,
  input  wire logic                                      cfg_wr_en,
  input  wire logic [gtpmc_pkg::GSIZE_W-1:0]             cfg_wr_data,
  output gtpmc_pkg::ctl_t                                ctl,
  input  wire logic [MAX_SIDE-1:0]                       new_v,
  input  wire logic [MAX_SIDE-1:0][$clog2(4*MAX_SIDE)-1:0] new_s,
  input  wire logic [MAX_SIDE-1:0][1:0]                  b_code
);
  import gtpmc_pkg::*;

  localparam int unsigned NSQ = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AW = $clog2(NSQ);
  localparam int unsigned LW = $clog2(NSQ + 1);
  localparam int unsigned RW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned SC_W = $clog2(4*MAX_SIDE);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_COPY  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DIAG  = 3'd3;
  localparam logic [2:0] S_RA    = 3'd4;
  localparam logic [2:0] S_RB    = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]         state_r;
  logic [GSIZE_W-1:0] grid_size_r;
  logic [LW-1:0]      load_cnt_r;
  logic [LW-1:0]      idx_r;
  logic [CTL_W-1:0]   cr_r, cc_r;
  logic [CTL_W-1:0]   t_r, row_r;
  logic               layer_r;
  logic [1:0]         flat_mem [2**AW];
  logic [1:0]         fq_r;
  logic               cp_we_r, cp_ld_r;
  logic [CTL_W-1:0]   cp_row_r, cp_col_r;
  logic [7:0]         res_r;
  logic               out_tvalid_r;
  logic [7:0]         out_total_r;

  logic [CTL_W-1:0]   n8;
  logic [15:0]        n_sq;
  logic               in_acc;
  logic [8:0]         t9, n9, t_end;
  logic [8:0]         lo9, hi9, lo_p9, hi_p9;
  logic [RW-1:0]      last_sel;
  logic [15:0]        sel_s;
  logic               last_row;

  always_comb begin
    if (grid_size_r == '0) begin
      n8 = CTL_W'(1);
    end else if (CTL_W'(grid_size_r) > CTL_W'(MAX_SIDE)) begin
      n8 = CTL_W'(MAX_SIDE);
    end else begin
      n8 = CTL_W'(grid_size_r);
    end
  end

  assign n_sq = 16'(n8) * 16'(n8);
  assign in_tready = (state_r == S_LOAD);
  assign in_acc = in_tvalid && in_tready;

  assign t9 = 9'(t_r);
  assign n9 = 9'(n8);
  assign t_end = (n9 << 1) - 9'd2;
  assign lo9 = (t9 + 9'd1 > n9) ? t9 + 9'd1 - n9 : 9'd0;
  assign hi9 = (t9 < n9 - 9'd1) ? t9 : n9 - 9'd1;
  // Range of the previous diagonal; empty on the first one.
  assign lo_p9 = (t9 == 9'd0) ? 9'd1 : ((t9 > n9) ? t9 - n9 : 9'd0);
  assign hi_p9 = (t9 == 9'd0) ? 9'd0 : ((t9 - 9'd1 < n9 - 9'd1) ? t9 - 9'd1 : n9 - 9'd1);
  assign last_row = (row_r == n8 - CTL_W'(1));
  assign last_sel = RW'(n8 - CTL_W'(1));
  assign sel_s = 16'(new_s[last_sel]);

  // Every row step writes and advances the previous-row score; rows outside the
  // diagonal are masked when they are read back.
  always_comb begin
    ctl.diag_rd = (state_r == S_DIAG);
    ctl.rd_en = (state_r == S_RA);
    ctl.wr_en = (state_r == S_RB);
    ctl.layer = layer_r;
    ctl.first = (t_r == '0);
    ctl.row_ok = (9'(row_r) >= lo_p9) && (9'(row_r) <= hi_p9);
    ctl.t = t_r;
    ctl.row = row_r;
    ctl.lo = CTL_W'(lo9);
    ctl.hi = CTL_W'(hi9);
    ctl.lo_p = CTL_W'(lo_p9);
    ctl.hi_p = CTL_W'(hi_p9);
    ctl.a_code = b_code[row_r[RW-1:0]];
    ctl.cp_we = cp_we_r;
    ctl.cp_row = cp_row_r;
    ctl.cp_col = cp_col_r;
    if (!cp_ld_r) begin
      ctl.cp_code = CELL_EMPTY;
    end else if (fq_r == CODE_ITEM) begin
      ctl.cp_code = CELL_ITEM;
    end else if (fq_r[1]) begin
      ctl.cp_code = CELL_BLOCKED;
    end else begin
      ctl.cp_code = CELL_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && 16'(load_cnt_r) < n_sq) begin
      flat_mem[load_cnt_r[AW-1:0]] <= in_code;
    end
    fq_r <= flat_mem[idx_r[AW-1:0]];
    cp_ld_r <= (idx_r < load_cnt_r);
    cp_row_r <= cr_r;
    cp_col_r <= cc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= GSIZE_RESET;
    end else if (cfg_wr_en) begin
      grid_size_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      load_cnt_r <= '0;
      idx_r <= '0;
      cr_r <= '0;
      cc_r <= '0;
      t_r <= '0;
      row_r <= '0;
      layer_r <= 1'b0;
      cp_we_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      cp_we_r <= (state_r == S_COPY);
      if (state_r == S_OUT && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (16'(load_cnt_r) < n_sq) begin
              load_cnt_r <= load_cnt_r + LW'(1);
            end
            if (in_tlast) begin
              state_r <= S_COPY;
              idx_r <= '0;
              cr_r <= '0;
              cc_r <= '0;
            end
          end
        end
        S_COPY: begin
          idx_r <= idx_r + LW'(1);
          if (cc_r == n8 - CTL_W'(1)) begin
            cc_r <= '0;
            cr_r <= cr_r + CTL_W'(1);
          end else begin
            cc_r <= cc_r + CTL_W'(1);
          end
          if (16'(idx_r) == n_sq - 16'd1) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_DIAG;
          t_r <= '0;
          layer_r <= 1'b0;
        end
        S_DIAG: begin
          row_r <= '0;
          state_r <= S_RA;
        end
        S_RA: begin
          state_r <= S_RB;
        end
        S_RB: begin
          if (last_row) begin
            if (t9 == t_end) begin
              if (!new_v[last_sel]) begin
                res_r <= 8'd0;
              end else if (sel_s > 16'd255) begin
                res_r <= 8'hFF;
              end else begin
                res_r <= 8'(sel_s);
              end
              state_r <= S_OUT;
            end else begin
              t_r <= t_r + CTL_W'(1);
              layer_r <= ~layer_r;
              state_r <= S_DIAG;
            end
          end else begin
            row_r <= row_r + CTL_W'(1);
            state_r <= S_RA;
          end
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_total_r <= res_r;
            load_cnt_r <= '0;
            state_r <= S_LOAD;
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_total = out_total_r;

`ifndef SYNTH
  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(load_cnt_r) <= NSQ)
    else $error("load count beyond grid store");
  a_ready_only_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == S_LOAD))
    else $error("input taken outside loading");
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_RA) || (state_r == S_RB)) |-> (row_r < n8))
    else $error("row index beyond grid side");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_tvalid_r && !out_tready) |=> (state_r == S_OUT))
    else $error("result overwritten while stalled");
`endif

endmodule
`default_nettype wire

@@ rtl/grid_two_path_max_collect_top.sv @@
// Top level of the two-walker grid collector: sequencer and a chain of column cells.
//
// Input channel (in_*): one grid cell per transaction in row-major order; in_tdata[1:0]
// holds the cell code (01 one item, 00 empty, 1x blocked), in_tlast marks the final cell.
// Cells beyond grid_size squared are dropped; cells never supplied count as empty.
// Output channel (out_*): one transaction per grid, out_tdata = best combined total
// of two right/down walks, a shared cell counted once, 0 if the goal is unreachable.
// Configuration: cfg_wr_en writes cfg_wr_data into grid_size (reset value 64).
// Loading accepts one cell per cycle while in_tvalid is high. After the last cell the block
// copies the grid into the per-row cell stores, then sweeps 2N-1 diagonals: every cell
// handles one r2 column, and the shared r1 row is stepped through one score-store read
// and one write per row. Input is not taken from the last cell until the result is in
// the output register. A stalled receiver holds the result; a further finished result
// waits until the register frees. Reset (rst_n low, synchronous) empties the load count
// and the output register; the grid and score stores keep stale contents, which are
// never read before being rewritten.
`default_nettype none
module grid_two_path_max_collect_top #(
  parameter int unsigned MAX_SIDE = gtpmc_pkg::DEF_MAX_SIDE
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,    // [1:0] cell_value, rest zero
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,   // [7:0] best_total
  input  wire logic       cfg_wr_en,
  input  wire logic [6:0] cfg_wr_data
);
  import gtpmc_pkg::*;

  localparam int unsigned SC_W = $clog2(4*MAX_SIDE);

  ctl_t ctl;
  logic [MAX_SIDE-1:0]            cur_v, prv_v, new_v;
  logic [MAX_SIDE-1:0][SC_W-1:0]  cur_s, prv_s, new_s;
  logic [MAX_SIDE-1:0][1:0]       b_code;

  gtpmc_ctrl #(.MAX_SIDE(MAX_SIDE)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_code    (in_tdata[1:0]),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_total  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .ctl        (ctl),
    .new_v      (new_v),
    .new_s      (new_s),
    .b_code     (b_code)
  );

  for (genvar k = 0; k < MAX_SIDE; k++) begin : g_cell
    logic            nb_cur_v, nb_prv_v;
    logic [SC_W-1:0] nb_cur_s, nb_prv_s;
    if (k == 0) begin : g_edge
      assign nb_cur_v = 1'b0;
      assign nb_cur_s = '0;
      assign nb_prv_v = 1'b0;
      assign nb_prv_s = '0;
    end else begin : g_link
      assign nb_cur_v = cur_v[k-1];
      assign nb_cur_s = cur_s[k-1];
      assign nb_prv_v = prv_v[k-1];
      assign nb_prv_s = prv_s[k-1];
    end
    gtpmc_cell #(.MAX_SIDE(MAX_SIDE), .IDX(k)) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .nb_cur_v(nb_cur_v),
      .nb_cur_s(nb_cur_s),
      .nb_prv_v(nb_prv_v),
      .nb_prv_s(nb_prv_s),
      .cur_v   (cur_v[k]),
      .cur_s   (cur_s[k]),
      .prv_v   (prv_v[k]),
      .prv_s   (prv_s[k]),
      .new_v   (new_v[k]),
      .new_s   (new_s[k]),
      .b_code  (b_code[k])
    );
  end

endmodule
`default_nettype wire

@@ tb/sv/tb_grid_two_path_max_collect_top.sv @@
// Self-checking testbench for the two-walker grid collector, using a directed table and random grids.
`default_nettype none
module tb_grid_two_path_max_collect_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE = gtpmc_pkg::DEF_MAX_SIDE;
  localparam logic [1:0] CODE_EMPTY = 2'b00;
  localparam logic [1:0] CODE_ITEM = gtpmc_pkg::CODE_ITEM;
  localparam logic [1:0] CODE_BLOCK = 2'b11;
  localparam logic [1:0] CODE_ALT_BLOCK = 2'b10;
  localparam int NO_PATH = -1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [6:0] cfg_wr_data = '0;

  grid_two_path_max_collect_top #(.MAX_SIDE(SIDE)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  // Predictor state.
  logic [6:0] side_reg = 7'd64;
  int grid_cells [SIDE*SIDE];
  int cells_loaded = 0;
  int score [2][SIDE][SIDE];
  logic [7:0] total_q[$];
  int mismatches = 0;
  bit quiet = 1'b0;

  function automatic int side_used();
    if (side_reg < 1) return 1;
    if (side_reg > SIDE) return SIDE;
    return side_reg;
  endfunction

  function automatic int cell_val(int r, int c, int n);
    int idx;
    idx = r * n + c;
    if (idx >= cells_loaded) return 0;
    return grid_cells[idx];
  endfunction

  function automatic int best_collect(int n);
    int cur, nxt, lo, hi, a, b, gain, best;
    cur = 0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) score[0][i][j] = NO_PATH;
    if (cell_val(0, 0, n) >= 0) score[0][0][0] = cell_val(0, 0, n);
    for (int t = 1; t + 2 <= 2 * n; t++) begin
      nxt = 1 - cur;
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) score[nxt][i][j] = NO_PATH;
      lo = (t + 1 > n) ? t + 1 - n : 0;
      hi = (t < n - 1) ? t : n - 1;
      for (int r1 = lo; r1 <= hi; r1++) begin
        for (int r2 = lo; r2 <= hi; r2++) begin
          a = cell_val(r1, t - r1, n);
          b = cell_val(r2, t - r2, n);
          if (a < 0 || b < 0) continue;
          gain = a + ((r1 == r2) ? 0 : b);
          best = score[cur][r1][r2];
          if (r1 > 0 && score[cur][r1-1][r2] > best) best = score[cur][r1-1][r2];
          if (r2 > 0 && score[cur][r1][r2-1] > best) best = score[cur][r1][r2-1];
          if (r1 > 0 && r2 > 0 && score[cur][r1-1][r2-1] > best)
            best = score[cur][r1-1][r2-1];
          if (best >= 0) score[nxt][r1][r2] = best + gain;
        end
      end
      cur = nxt;
    end
    best = score[cur][n-1][n-1];
    if (best < 0) best = 0;
    if (best > 255) best = 255;
    return best;
  endfunction

  // Sends one cell, updates the predictor on acceptance; fixed_total >= 0 overrides
  // the predicted total with a value read straight off the grid.
  task automatic send_cell(input logic [1:0] code, input bit last, input int fixed_total);
    int n, v, tot;
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, code};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    n = side_used();
    v = (code == CODE_ITEM) ? 1 : (code == CODE_EMPTY) ? 0 : -1;
    if (cells_loaded < n * n) begin
      grid_cells[cells_loaded] = v;
      cells_loaded++;
    end
    if (last) begin
      tot = best_collect(n);
      total_q.push_back((fixed_total >= 0) ? fixed_total[7:0] : tot[7:0]);
      cells_loaded = 0;
    end
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Register writes happen only once every result is out and the sweep has wound down.
  task automatic write_size(input logic [6:0] val);
    in_tvalid <= 1'b0;
    while (total_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    side_reg = val;
  endtask

  // Receiver side: random stall bursts, none in the final stretch.
  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (total_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: %0d", out_tdata);
      end else begin
        if (out_tdata !== total_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("best_total mismatch: expected %0d, got %0d", total_q[0], out_tdata);
        end
        void'(total_q.pop_front());
      end
    end
  end

  typedef struct {
    bit is_cfg;
    logic [6:0] size_val;
    logic [1:0] code;
    bit last;
    int total;
  } step_t;

  step_t steps[$] = '{
    '{0, 7'd0, CODE_ITEM, 1, 1},        // default side 64, only the corner holds an item
    '{0, 7'd0, CODE_EMPTY, 1, 0},
    '{0, 7'd0, CODE_BLOCK, 1, 0},       // blocked start
    '{0, 7'd0, CODE_ALT_BLOCK, 1, 0},   // the other blocked pattern
    '{1, 7'd2, CODE_EMPTY, 0, -1},
    '{0, 7'd0, CODE_ITEM, 0, -1},
    '{0, 7'd0, CODE_ITEM, 0, -1},
    '{0, 7'd0, CODE_ITEM, 0, -1},
    '{0, 7'd0, CODE_ITEM, 1, 3},
    '{0, 7'd0, CODE_ITEM, 0, -1},
    '{0, 7'd0, CODE_ALT_BLOCK, 0, -1},
    '{0, 7'd0, CODE_BLOCK, 0, -1},
    '{0, 7'd0, CODE_ITEM, 1, 0},
    '{0, 7'd0, CODE_ITEM, 0, -1},
    '{0, 7'd0, CODE_ITEM, 0, -1},
    '{0, 7'd0, CODE_EMPTY, 0, -1},
    '{0, 7'd0, CODE_BLOCK, 1, 0},       // blocked goal
    '{1, 7'd0, CODE_ITEM, 1, 1},        // size zero behaves as one
    '{1, 7'd1, CODE_ITEM, 0, -1},
    '{0, 7'd0, CODE_ITEM, 0, -1},       // surplus cells are dropped
    '{0, 7'd0, CODE_ITEM, 1, 1},
    '{1, 7'd127, CODE_ITEM, 0, -1},     // clamps to the largest side, grid ends early
    '{0, 7'd0, CODE_ITEM, 1, 2}
  };

  function automatic logic [1:0] rand_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 14) return $urandom_range(0, 1) ? CODE_BLOCK : CODE_ALT_BLOCK;
    if (r < 55) return CODE_ITEM;
    return CODE_EMPTY;
  endfunction

  initial begin
    int sent, n, cells, kind;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (steps[i]) begin
      if (steps[i].is_cfg) write_size(steps[i].size_val);
      send_cell(steps[i].code, steps[i].last, steps[i].total);
    end
    // A full-size grid of items on a three-wide board.
    write_size(7'd3);
    for (int i = 0; i < 9; i++) send_cell(CODE_ITEM, i == 8, (i == 8) ? 8 : -1);

    sent = 0;
    while (sent < 1500) begin
      write_size($urandom_range(0, 9) == 0 ? 7'($urandom_range(10, 14))
                                           : 7'($urandom_range(1, 8)));
      n = side_used();
      repeat ($urandom_range(2, 6)) begin
        kind = $urandom_range(0, 9);
        cells = n * n;
        if (kind == 0) cells = $urandom_range(1, n * n);
        else if (kind == 1) cells = n * n + $urandom_range(1, 5);
        for (int i = 0; i < cells; i++) begin
          // Mostly keep the start and goal open so paths survive.
          if ((i == 0 || i == n * n - 1) && kind > 2)
            send_cell($urandom_range(0, 1) ? CODE_ITEM : CODE_EMPTY, i == cells - 1, -1);
          else
            send_cell(rand_code(), i == cells - 1, -1);
        end
        sent += cells;
        if (sent > 1200) quiet = 1'b1;
      end
    end
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;
    while (total_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/gtpmc_pkg.sv
rtl/gtpmc_cell.sv
rtl/gtpmc_ctrl.sv
rtl/grid_two_path_max_collect_top.sv
tb/sv/tb_grid_two_path_max_collect_top.sv
